### rtl/core/jsch_pkg.sv
// shared types and constants of the popularity job scheduler
// table entry layout, command, status and event codes, sequencer states
// no dependencies
package jsch_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int REG_WIDTH           = 7;
   localparam logic [REG_WIDTH-1:0] MAX_RUNNING_RESET = 7'd8;
   localparam logic [REG_WIDTH-1:0] MAX_ENTRIES_RESET = 7'd64;

   // command codes
   localparam logic [1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [1:0] CMD_COMPLETE = 2'd1;
   localparam logic [1:0] CMD_FAIL     = 2'd2;

   // entry status codes
   localparam logic [1:0] STAT_QUEUED  = 2'd0;
   localparam logic [1:0] STAT_RUNNING = 2'd1;
   localparam logic [1:0] STAT_RETRY   = 2'd2;

   // event codes
   localparam logic [1:0] EV_START      = 2'd0;
   localparam logic [1:0] EV_CANCEL_NEW = 2'd1;
   localparam logic [1:0] EV_CANCEL_OLD = 2'd2;
   localparam logic [1:0] EV_ERROR      = 2'd3;

   // register indexes
   localparam logic REG_MAX_RUNNING = 1'b0;
   localparam logic REG_MAX_ENTRIES = 1'b1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] count;
      logic [15:0] request;
      logic [31:0] fail_time;
   } entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_EMIT1,
      S_EMIT2
   } state_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

### rtl/core/jsch_table.sv
// job table memory: one write port, one registered read port
// depends on jsch_pkg for the entry layout
module jsch_table #(
   parameter int DEPTH = jsch_pkg::TABLE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  jsch_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output jsch_pkg::entry_type rd_data
);
   import jsch_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/jsch_scan.sv
// table scan accumulator: key match, used count, oldest retry entry,
// lowest free slot and top queued entry; depends on jsch_pkg
module jsch_scan #(
   parameter int DEPTH = jsch_pkg::TABLE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int UW    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                rd_issue,
   input  logic [AW-1:0]       rd_addr,
   input  jsch_pkg::entry_type rd_data,
   input  logic [31:0]         key,
   output logic                match_found,
   output logic [AW-1:0]       match_idx,
   output jsch_pkg::entry_type match_entry,
   output logic [UW-1:0]       used,
   output logic                retry_found,
   output logic [AW-1:0]       retry_idx,
   output logic                free_found,
   output logic [AW-1:0]       free_idx,
   output logic                top_found,
   output logic [AW-1:0]       top_idx,
   output jsch_pkg::entry_type top_entry
);
   import jsch_pkg::*;

   logic            rvalid_ff;
   logic [AW-1:0]   ridx_ff;
   logic            match_found_ff, match_found_in;
   logic [AW-1:0]   match_idx_ff, match_idx_in;
   entry_type       match_entry_ff, match_entry_in;
   logic [UW-1:0]   used_ff, used_in;
   logic            retry_found_ff, retry_found_in;
   logic [AW-1:0]   retry_idx_ff, retry_idx_in;
   logic [31:0]     retry_time_ff, retry_time_in;
   logic            free_found_ff, free_found_in;
   logic [AW-1:0]   free_idx_ff, free_idx_in;
   logic            top_found_ff, top_found_in;
   logic [AW-1:0]   top_idx_ff, top_idx_in;
   entry_type       top_entry_ff, top_entry_in;

   // read data belongs to the address issued in the cycle before
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rd_issue;
      end
      ridx_ff <= rd_addr;
   end

   // clear the running results, or fold one entry into them
   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_entry_in = match_entry_ff;
      used_in        = used_ff;
      retry_found_in = retry_found_ff;
      retry_idx_in   = retry_idx_ff;
      retry_time_in  = retry_time_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      top_found_in   = top_found_ff;
      top_idx_in     = top_idx_ff;
      top_entry_in   = top_entry_ff;
      if (clear) begin
         match_found_in = 1'b0;
         used_in        = '0;
         retry_found_in = 1'b0;
         free_found_in  = 1'b0;
         top_found_in   = 1'b0;
      end else if (rvalid_ff) begin
         if (rd_data.valid) begin
            used_in = used_ff + UW'(1);
            if (rd_data.key == key && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = ridx_ff;
               match_entry_in = rd_data;
            end
            if (rd_data.status == STAT_RETRY &&
                (!retry_found_ff || rd_data.fail_time < retry_time_ff)) begin
               retry_found_in = 1'b1;
               retry_idx_in   = ridx_ff;
               retry_time_in  = rd_data.fail_time;
            end
            if (rd_data.status == STAT_QUEUED &&
                (!top_found_ff || rd_data.count > top_entry_ff.count)) begin
               top_found_in = 1'b1;
               top_idx_in   = ridx_ff;
               top_entry_in = rd_data;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = ridx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         used_ff        <= '0;
         retry_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         top_found_ff   <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         used_ff        <= used_in;
         retry_found_ff <= retry_found_in;
         free_found_ff  <= free_found_in;
         top_found_ff   <= top_found_in;
      end
      match_idx_ff   <= match_idx_in;
      match_entry_ff <= match_entry_in;
      retry_idx_ff   <= retry_idx_in;
      retry_time_ff  <= retry_time_in;
      free_idx_ff    <= free_idx_in;
      top_idx_ff     <= top_idx_in;
      top_entry_ff   <= top_entry_in;
   end

   assign match_found = match_found_ff;
   assign match_idx   = match_idx_ff;
   assign match_entry = match_entry_ff;
   assign used        = used_ff;
   assign retry_found = retry_found_ff;
   assign retry_idx   = retry_idx_ff;
   assign free_found  = free_found_ff;
   assign free_idx    = free_idx_ff;
   assign top_found   = top_found_ff;
   assign top_idx     = top_idx_ff;
   assign top_entry   = top_entry_ff;

endmodule

### rtl/core/popularity_job_scheduler_core.sv
// popularity job scheduler: one transaction scans the table in a pass of SCAN, DRAIN
// and DECIDE, then a second pass picks the queued job to start; each eviction of a retry
// entry adds one pass. Busy stays high through every pass and every result.
// Results appear one per cycle, up to two, and cannot be held off by the receiver.
// Synchronous reset clears control state and runs a clearing pass over all entries of
// the table during which busy stays high; configuration writes are taken throughout.
module popularity_job_scheduler_core #(
   parameter int TABLE_DEPTH = jsch_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_job_key,
   input  logic [15:0] req_request_tag,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [1:0]  rsp_event_kind,
   output logic [15:0] rsp_event_tag,
   output logic [31:0] rsp_event_key,
   output logic        rsp_last_event,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import jsch_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int UW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (UW > REG_WIDTH) ? UW : REG_WIDTH;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   state_type             state_ff, state_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic                  phase_ff, phase_in;
   logic [1:0]            cmd_ff;
   logic [31:0]           key_ff;
   logic [15:0]           tag_ff;
   logic [31:0]           now_ff;
   logic                  ev1_v_ff, ev1_v_in;
   logic [1:0]            ev1_kind_ff, ev1_kind_in;
   logic [15:0]           ev1_tag_ff, ev1_tag_in;
   logic [31:0]           ev1_key_ff, ev1_key_in;
   logic                  ev2_v_ff, ev2_v_in;
   logic [15:0]           ev2_tag_ff, ev2_tag_in;
   logic [31:0]           ev2_key_ff, ev2_key_in;
   logic [REG_WIDTH-1:0]  run_total_ff, run_total_in;
   logic [REG_WIDTH-1:0]  max_run_ff;
   logic [REG_WIDTH-1:0]  max_ent_ff;

   logic                  accept;
   logic                  csr_write;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   entry_type             wr_data;
   logic                  rd_issue;
   entry_type             rd_data;
   logic                  scan_clear;
   logic [CW-1:0]         limit;
   logic                  table_full;

   logic                  match_found;
   logic [AW-1:0]         match_idx;
   entry_type             match_entry;
   logic [UW-1:0]         used;
   logic                  retry_found;
   logic [AW-1:0]         retry_idx;
   logic                  free_found;
   logic [AW-1:0]         free_idx;
   logic                  top_found;
   logic [AW-1:0]         top_idx;
   entry_type             top_entry;

   jsch_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   jsch_scan #(.DEPTH(TABLE_DEPTH), .AW(AW), .UW(UW)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (scan_clear),
      .rd_issue    (rd_issue),
      .rd_addr     (addr_ff),
      .rd_data     (rd_data),
      .key         (key_ff),
      .match_found (match_found),
      .match_idx   (match_idx),
      .match_entry (match_entry),
      .used        (used),
      .retry_found (retry_found),
      .retry_idx   (retry_idx),
      .free_found  (free_found),
      .free_idx    (free_idx),
      .top_found   (top_found),
      .top_idx     (top_idx),
      .top_entry   (top_entry)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign csr_write  = psel && penable && pwrite && pready;
   assign pready     = 1'b1;
   assign rd_issue   = (state_ff == S_SCAN);
   assign scan_clear = (state_ff == S_SCAN) && (addr_ff == '0);

   // table limit is the smaller of the register and the depth
   always_comb begin
      if (CW'(max_ent_ff) < CW'(TABLE_DEPTH)) begin
         limit = CW'(max_ent_ff);
      end else begin
         limit = CW'(TABLE_DEPTH);
      end
   end
   assign table_full = (CW'(used) >= limit);

   // register read back
   always_comb begin
      case (paddr[2])
         REG_MAX_RUNNING: prdata = {{(32-REG_WIDTH){1'b0}}, max_run_ff};
         REG_MAX_ENTRIES: prdata = {{(32-REG_WIDTH){1'b0}}, max_ent_ff};
         default:         prdata = '0;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff <= MAX_RUNNING_RESET;
         max_ent_ff <= MAX_ENTRIES_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_MAX_RUNNING: max_run_ff <= pwdata[REG_WIDTH-1:0];
            REG_MAX_ENTRIES: max_ent_ff <= pwdata[REG_WIDTH-1:0];
            default:         max_run_ff <= max_run_ff;
         endcase
      end
   end

   // captured transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_job_key;
         tag_ff <= req_request_tag;
         now_ff <= req_now_ms;
      end
   end

   // sequencer: clearing pass, scan passes, table update, result output
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      phase_in     = phase_ff;
      ev1_v_in     = ev1_v_ff;
      ev1_kind_in  = ev1_kind_ff;
      ev1_tag_in   = ev1_tag_ff;
      ev1_key_in   = ev1_key_ff;
      ev2_v_in     = ev2_v_ff;
      ev2_tag_in   = ev2_tag_ff;
      ev2_key_in   = ev2_key_ff;
      run_total_in = run_total_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               addr_in  = '0;
               phase_in = 1'b0;
               ev1_v_in = 1'b0;
               ev2_v_in = 1'b0;
            end
         end
         S_SCAN: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!phase_ff) begin
               // apply the command, then rescan for the start decision
               phase_in = 1'b1;
               state_in = S_SCAN;
               addr_in  = '0;
               wr_data  = match_entry;
               wr_addr  = match_idx;
               case (cmd_ff)
                  CMD_SCHEDULE: begin
                     if (match_found) begin
                        wr_en         = 1'b1;
                        wr_data.count = sat_inc(match_entry.count);
                        if (match_entry.status == STAT_RUNNING) begin
                           ev1_v_in    = 1'b1;
                           ev1_kind_in = EV_CANCEL_NEW;
                           ev1_tag_in  = tag_ff;
                           ev1_key_in  = key_ff;
                        end else begin
                           if (match_entry.status == STAT_QUEUED) begin
                              ev1_v_in    = 1'b1;
                              ev1_kind_in = EV_CANCEL_OLD;
                              ev1_tag_in  = match_entry.request;
                              ev1_key_in  = key_ff;
                           end
                           wr_data.status  = STAT_QUEUED;
                           wr_data.request = tag_ff;
                        end
                     end else if (table_full) begin
                        if (retry_found) begin
                           // evict the oldest retry entry and look again
                           wr_en    = 1'b1;
                           wr_addr  = retry_idx;
                           wr_data  = '0;
                           phase_in = 1'b0;
                        end else begin
                           ev1_v_in    = 1'b1;
                           ev1_kind_in = EV_CANCEL_NEW;
                           ev1_tag_in  = tag_ff;
                           ev1_key_in  = key_ff;
                        end
                     end else if (free_found) begin
                        wr_en             = 1'b1;
                        wr_addr           = free_idx;
                        wr_data.valid     = 1'b1;
                        wr_data.status    = STAT_QUEUED;
                        wr_data.key       = key_ff;
                        wr_data.count     = 32'd1;
                        wr_data.request   = tag_ff;
                        wr_data.fail_time = '0;
                     end
                  end
                  CMD_COMPLETE, CMD_FAIL: begin
                     if (match_found && match_entry.status == STAT_RUNNING) begin
                        wr_en = 1'b1;
                        if (run_total_ff != '0) begin
                           run_total_in = run_total_ff - REG_WIDTH'(1);
                        end
                        if (cmd_ff == CMD_COMPLETE) begin
                           wr_data = '0;
                        end else begin
                           wr_data.status    = STAT_RETRY;
                           wr_data.fail_time = now_ff;
                        end
                     end else begin
                        ev1_v_in    = 1'b1;
                        ev1_kind_in = EV_ERROR;
                        ev1_tag_in  = '0;
                        ev1_key_in  = key_ff;
                     end
                  end
                  default: begin
                     ev1_v_in    = 1'b1;
                     ev1_kind_in = EV_ERROR;
                     ev1_tag_in  = '0;
                     ev1_key_in  = key_ff;
                  end
               endcase
            end else begin
               // start the top queued entry if a run slot is free
               wr_addr = top_idx;
               wr_data = top_entry;
               if (run_total_ff < max_run_ff && top_found) begin
                  wr_en          = 1'b1;
                  wr_data.status = STAT_RUNNING;
                  run_total_in   = run_total_ff + REG_WIDTH'(1);
                  ev2_v_in       = 1'b1;
                  ev2_tag_in     = top_entry.request;
                  ev2_key_in     = top_entry.key;
               end
               if (ev1_v_ff) begin
                  state_in = S_EMIT1;
               end else if (run_total_ff < max_run_ff && top_found) begin
                  state_in = S_EMIT2;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT1: begin
            state_in = ev2_v_ff ? S_EMIT2 : S_IDLE;
         end
         S_EMIT2: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         phase_ff     <= 1'b0;
         ev1_v_ff     <= 1'b0;
         ev2_v_ff     <= 1'b0;
         run_total_ff <= '0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         phase_ff     <= phase_in;
         ev1_v_ff     <= ev1_v_in;
         ev2_v_ff     <= ev2_v_in;
         run_total_ff <= run_total_in;
      end
      ev1_kind_ff <= ev1_kind_in;
      ev1_tag_ff  <= ev1_tag_in;
      ev1_key_ff  <= ev1_key_in;
      ev2_tag_ff  <= ev2_tag_in;
      ev2_key_ff  <= ev2_key_in;
   end

   // result ports
   always_comb begin
      rsp_valid      = 1'b0;
      rsp_event_kind = ev1_kind_ff;
      rsp_event_tag  = ev1_tag_ff;
      rsp_event_key  = ev1_key_ff;
      rsp_last_event = 1'b0;
      case (state_ff)
         S_EMIT1: begin
            rsp_valid      = 1'b1;
            rsp_last_event = !ev2_v_ff;
         end
         S_EMIT2: begin
            rsp_valid      = 1'b1;
            rsp_event_kind = EV_START;
            rsp_event_tag  = ev2_tag_ff;
            rsp_event_key  = ev2_key_ff;
            rsp_last_event = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/jsch_checker.sv
// port-level checks of the popularity job scheduler and their binding
// depends on jsch_pkg and popularity_job_scheduler_core
module jsch_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_event_kind,
   input logic       rsp_last_event
);
   import jsch_pkg::*;

   // results only come while a transaction is in flight
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a transaction");

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");

   // a non-final result is followed at once by the next one
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_event) |=> (rsp_valid && rsp_last_event))
      else $error("missing final result");

   // nothing after the final result of a transaction
   a_end_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_event) |=> !rsp_valid)
      else $error("result after final result");

   // a start is always the last result of its transaction
   a_start_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_START) |-> rsp_last_event)
      else $error("start not final");

endmodule

bind popularity_job_scheduler_core jsch_checker u_jsch_checker (.*);

### tb/tb.sv
// self-checking testbench of popularity_job_scheduler_core
// mirrors the job table in the bench and checks every event; needs rtl/core/jsch_pkg.sv
module tb;
   import jsch_pkg::*;

   localparam int DEPTH = 64;
   localparam int STALL_LIMIT = 40000;
   localparam int PHASES = 6;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [15:0] tag;
      logic [31:0] now;
   } job_req_type;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] tag;
      logic [31:0] key;
      logic        last;
   } sched_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = '0;
   logic [31:0] req_job_key = '0;
   logic [15:0] req_request_tag = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_event_kind;
   logic [15:0] rsp_event_tag;
   logic [31:0] rsp_event_key;
   logic        rsp_last_event;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   popularity_job_scheduler_core uut (.*);

   // mirror of the job table
   logic        tbl_valid [DEPTH];
   logic [1:0]  tbl_status [DEPTH];
   logic [31:0] tbl_key [DEPTH];
   logic [31:0] tbl_count [DEPTH];
   logic [15:0] tbl_request [DEPTH];
   logic [31:0] tbl_fail_time [DEPTH];
   int unsigned run_total;
   int unsigned lim_running;
   int unsigned lim_entries;

   job_req_type     pending_jobs[$];
   sched_event_type pending_events[$];
   int  errors = 0;
   int  stall_cycles = 0;
   int  gap_left = 0;
   logic took = 1'b0;
   logic calm = 1'b0;
   logic [31:0] key_pool [16];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic void add_event(input logic [1:0] kind, input logic [15:0] tag,
                                     input logic [31:0] key);
      sched_event_type e;
      e.kind = kind;
      e.tag = tag;
      e.key = key;
      e.last = 1'b0;
      pending_events.push_back(e);
   endfunction

   function automatic int lookup(input logic [31:0] key);
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   // free oldest retry entries while full, then return lowest free slot
   function automatic int claim_slot();
      int unsigned cap;
      int unsigned used;
      int oldest;
      cap = (lim_entries < DEPTH) ? lim_entries : DEPTH;
      forever begin
         used = 0;
         for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) used++;
         if (used < cap) break;
         oldest = -1;
         for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_status[i] == STAT_RETRY &&
                (oldest < 0 || tbl_fail_time[i] < tbl_fail_time[oldest]))
               oldest = i;
         if (oldest < 0) return -1;
         tbl_valid[oldest] = 1'b0;
      end
      for (int i = 0; i < DEPTH; i++) if (!tbl_valid[i]) return i;
      return -1;
   endfunction

   // expected events of one accepted transaction
   function automatic void predict_events(input job_req_type j);
      int s;
      int best;
      int first;
      first = pending_events.size();
      s = lookup(j.key);
      if (j.cmd == CMD_SCHEDULE) begin
         if (s < 0) begin
            s = claim_slot();
            if (s < 0) add_event(EV_CANCEL_NEW, j.tag, j.key);
            else begin
               tbl_valid[s] = 1'b1;
               tbl_key[s] = j.key;
               tbl_status[s] = STAT_QUEUED;
               tbl_count[s] = 32'd1;
               tbl_request[s] = j.tag;
               tbl_fail_time[s] = '0;
            end
         end else if (tbl_status[s] == STAT_RUNNING) begin
            tbl_count[s] = bump(tbl_count[s]);
            add_event(EV_CANCEL_NEW, j.tag, j.key);
         end else begin
            if (tbl_status[s] == STAT_QUEUED) add_event(EV_CANCEL_OLD, tbl_request[s], j.key);
            tbl_count[s] = bump(tbl_count[s]);
            tbl_status[s] = STAT_QUEUED;
            tbl_request[s] = j.tag;
         end
      end else if (j.cmd == CMD_COMPLETE || j.cmd == CMD_FAIL) begin
         if (s < 0 || tbl_status[s] != STAT_RUNNING) add_event(EV_ERROR, '0, j.key);
         else begin
            if (run_total > 0) run_total--;
            if (j.cmd == CMD_COMPLETE) tbl_valid[s] = 1'b0;
            else begin
               tbl_status[s] = STAT_RETRY;
               tbl_fail_time[s] = j.now;
            end
         end
      end else begin
         add_event(EV_ERROR, '0, j.key);
      end
      // start the most popular queued job if a run slot is free
      if (run_total < lim_running) begin
         best = -1;
         for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_status[i] == STAT_QUEUED &&
                (best < 0 || tbl_count[i] > tbl_count[best]))
               best = i;
         if (best >= 0) begin
            tbl_status[best] = STAT_RUNNING;
            run_total++;
            add_event(EV_START, tbl_request[best], tbl_key[best]);
         end
      end
      if (pending_events.size() > first)
         pending_events[pending_events.size()-1].last = 1'b1;
   endfunction

   // accept transactions, mirror register writes, check events, watchdog
   always @(posedge clock) begin
      sched_event_type e;
      job_req_type j;
      logic active;
      active = 1'b0;
      took <= start && !busy;
      if (!reset && start && !busy) begin
         j.cmd = req_cmd;
         j.key = req_job_key;
         j.tag = req_request_tag;
         j.now = req_now_ms;
         predict_events(j);
         active = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
         if (paddr == 3'd4 * REG_MAX_RUNNING) lim_running = 32'(pwdata[6:0]);
         else if (paddr == 3'd4 * REG_MAX_ENTRIES) lim_entries = 32'(pwdata[6:0]);
         active = 1'b1;
      end
      if (!reset && rsp_valid) begin
         active = 1'b1;
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event kind %0d tag %h key %h", $time,
                     rsp_event_kind, rsp_event_tag, rsp_event_key);
            errors++;
         end else begin
            e = pending_events.pop_front();
            if (rsp_event_kind !== e.kind) begin
               $display("%0t: event_kind expected %0d actual %0d", $time, e.kind, rsp_event_kind);
               errors++;
            end
            if (rsp_event_tag !== e.tag) begin
               $display("%0t: event_tag expected %h actual %h", $time, e.tag, rsp_event_tag);
               errors++;
            end
            if (rsp_event_key !== e.key) begin
               $display("%0t: event_key expected %h actual %h", $time, e.key, rsp_event_key);
               errors++;
            end
            if (rsp_last_event !== e.last) begin
               $display("%0t: last_event expected %0d actual %0d", $time, e.last,
                        rsp_last_event);
               errors++;
            end
         end
      end
      stall_cycles <= active ? 0 : stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // driver: hold each transaction until accepted, random idle bursts
   always @(negedge clock) begin
      job_req_type j;
      if (!reset) begin
         if (start && !took) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_jobs.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 6);
            start <= 1'b0;
         end else if (pending_jobs.size() > 0) begin
            j = pending_jobs.pop_front();
            req_cmd <= j.cmd;
            req_job_key <= j.key;
            req_request_tag <= j.tag;
            req_now_ms <= j.now;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic queue_job(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [15:0] tag, input logic [31:0] now);
      job_req_type j;
      j.cmd = cmd;
      j.key = key;
      j.tag = tag;
      j.now = now;
      pending_jobs.push_back(j);
   endtask

   // wait for all transactions and events, then for the block to go idle
   task automatic drain();
      while (pending_jobs.size() > 0 || start || pending_events.size() > 0)
         @(negedge clock);
      while (busy) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic csr_write(input logic addr_sel, input logic [6:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 3'd4 * addr_sel;
      pwdata <= {25'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int unsigned run_cfg [PHASES];
      int unsigned ent_cfg [PHASES];
      int unsigned pool_n;
      int unsigned r;
      logic [1:0] c;
      logic [31:0] k;
      run_cfg = '{8, 1, 64, 2, 5, 3};
      ent_cfg = '{64, 1, 64, 3, 10, 6};
      for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
      run_total = 0;
      lim_running = 32'(MAX_RUNNING_RESET);
      lim_entries = 32'(MAX_ENTRIES_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, each special case
      queue_job(CMD_SCHEDULE, 32'h0, 16'h0000, 32'h0);
      queue_job(CMD_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      queue_job(CMD_SCHEDULE, 32'h1234_5678, 16'h00A5, 32'h0);
      queue_job(CMD_SCHEDULE, 32'h1234_5678, 16'h5A00, 32'h0);
      queue_job(CMD_SCHEDULE, 32'h0, 16'h1111, 32'h0);
      queue_job(CMD_FAIL, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF);
      queue_job(CMD_FAIL, 32'h0, 16'h0, 32'h0);
      queue_job(CMD_SCHEDULE, 32'h0, 16'h2222, 32'h0);
      queue_job(CMD_COMPLETE, 32'h0, 16'h0, 32'h0);
      queue_job(CMD_COMPLETE, 32'hDEAD_BEEF, 16'h0, 32'h0);
      queue_job(CMD_FAIL, 32'hDEAD_BEEF, 16'h0, 32'h0);
      queue_job(CMD_RESERVED, 32'hA5A5_A5A5, 16'hFFFF, 32'hFFFF_FFFF);
      queue_job(CMD_COMPLETE, 32'h1234_5678, 16'h0, 32'h0);
      queue_job(CMD_SCHEDULE, 32'hFFFF_FFFF, 16'h3333, 32'h0);
      drain();

      // phases of register settings with random traffic
      for (int p = 0; p < PHASES; p++) begin
         csr_write(REG_MAX_RUNNING, 7'(run_cfg[p]));
         csr_write(REG_MAX_ENTRIES, 7'(ent_cfg[p]));
         key_pool[0] = 32'h0;
         key_pool[1] = 32'hFFFF_FFFF;
         for (int i = 2; i < 16; i++) key_pool[i] = $urandom;
         pool_n = (p % 2 == 0) ? 16 : 6;
         if (p == PHASES - 1) calm = 1'b1;
         for (int n = 0; n < 150; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) c = CMD_SCHEDULE;
            else if (r < 76) c = CMD_COMPLETE;
            else if (r < 96) c = CMD_FAIL;
            else c = CMD_RESERVED;
            k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n-1)];
            queue_job(c, k, 16'($urandom), $urandom);
         end
         drain();
      end

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

### popularity_job_scheduler_core.f
rtl/core/jsch_pkg.sv
rtl/core/jsch_table.sv
rtl/core/jsch_scan.sv
rtl/core/popularity_job_scheduler_core.sv
rtl/core/jsch_checker.sv
tb/tb.sv
